[rtl/lzwsd_pkg.sv]
// Shared constants and types for the LZW stream decoder.
// No dependencies; imported by the core and the chain walker.
`timescale 1ns / 1ps

package lzwsd_pkg;

    localparam int LZWSD_MAX_WIDTH_BITS = 12;
    localparam int LITERAL_CODES        = 256;
    localparam int MIN_CODE_WIDTH       = 9;

    // operation codes (s_tuser)
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // decoder modes
    localparam logic [2:0] MODE_COLLECT = 3'd0;
    localparam logic [2:0] MODE_DRAIN   = 3'd1;
    localparam logic [2:0] MODE_AWAIT   = 3'd2;
    localparam logic [2:0] MODE_ENDED   = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    // error kinds
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_LIMIT     = 2'd2;
    localparam logic [1:0] ERR_CHAIN     = 2'd3;

    // status codes
    localparam logic [1:0] ST_PROGRESS   = 2'd0;
    localparam logic [1:0] ST_NEED_INPUT = 2'd1;
    localparam logic [1:0] ST_END        = 2'd2;
    localparam logic [1:0] ST_ERROR      = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MAX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_SIZE = 2'd1;
    localparam logic [1:0] CFG_IN_LIMIT   = 2'd2;

    typedef struct packed {
        logic       done;
        logic       ok;
        logic [7:0] val;
    } walk_res_t;

endpackage

[rtl/lzwsd_dict_ram.sv]
// Dictionary memory: one write port, one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module lzwsd_dict_ram #(
    parameter int AW    = 12,
    parameter int DW    = 41,
    parameter int DEPTH = 3840
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/lzwsd_chain_walk.sv]
// Prefix chain walker: finds byte 'off' of the phrase for a code, one
// dictionary read and one compare step per link. Uses lzwsd_pkg.
`timescale 1ns / 1ps

module lzwsd_chain_walk #(
    parameter int CW = 12,
    parameter int LW = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [CW-1:0]           start_code,
    input  logic [LW-1:0]           start_off,
    input  logic [CW:0]             next_free,
    output logic                    rd_en,
    output logic [CW-1:0]           rd_addr,
    input  logic [CW+LW+15:0]       rd_data,
    output lzwsd_pkg::walk_res_t    res
);
    import lzwsd_pkg::*;

    localparam logic [1:0] W_IDLE  = 2'd0;
    localparam logic [1:0] W_CHECK = 2'd1;
    localparam logic [1:0] W_EVAL  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] code_reg, code_next;
    logic [LW-1:0] off_reg, off_next;
    walk_res_t     res_reg, res_next;

    logic [LW-1:0] e_len;
    logic [7:0]    e_trail;
    logic [CW-1:0] e_prefix;

    assign e_len    = rd_data[LW-1:0];
    assign e_trail  = rd_data[LW+15:LW+8];
    assign e_prefix = rd_data[CW+LW+15:LW+16];
    assign rd_addr  = code_reg - CW'(LITERAL_CODES);
    assign res      = res_reg;

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        off_next   = off_reg;
        res_next   = '0;
        rd_en      = 1'b0;
        case (state_reg)
            W_IDLE: begin
                if (start) begin
                    code_next  = start_code;
                    off_next   = start_off;
                    state_next = W_CHECK;
                end
            end
            W_CHECK: begin
                if (code_reg[CW-1:8] == '0) begin
                    // literal ends the chain
                    res_next.done = 1'b1;
                    res_next.ok   = (off_reg == '0);
                    res_next.val  = code_reg[7:0];
                    state_next    = W_IDLE;
                end else if ({1'b0, code_reg} >= next_free) begin
                    res_next.done = 1'b1;
                    state_next    = W_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = W_EVAL;
                end
            end
            W_EVAL: begin
                if (e_len != '0 && (e_len - LW'(1)) == off_reg) begin
                    res_next.done = 1'b1;
                    res_next.ok   = 1'b1;
                    res_next.val  = e_trail;
                    state_next    = W_IDLE;
                end else if (e_len <= off_reg || e_prefix >= code_reg) begin
                    res_next.done = 1'b1;
                    state_next    = W_IDLE;
                end else begin
                    code_next  = e_prefix;
                    state_next = W_CHECK;
                end
            end
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= W_IDLE;
            res_reg   <= '0;
            code_reg  <= '0;
            off_reg   <= '0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
            code_reg  <= code_next;
            off_reg   <= off_next;
        end
    end

endmodule

[rtl/lzw_stream_decoder_core.sv]
// Top level of the streaming LZW decoder: sequencer, code assembly, dictionary
// update. Uses lzwsd_pkg, lzwsd_dict_ram and lzwsd_chain_walk.
`timescale 1ns / 1ps

// Usage:
//  s_ channel: one word per operation. s_tuser = operation (push / pull /
//  end of input / no-op), s_tdata[7:0] = compressed byte for a push.
//  m_ channel: exactly one result word per input word. m_tuser[0] is
//  out_valid; m_tdata carries accepted, out_byte, status and error_kind.
//  cfg_ channel: register writes (0 max code width, 1 frame size,
//  2 input limit), always ready; write only while the decoder is idle.
//  Timing: s_tready is high only while the sequencer is idle. A push that
//  completes a code passes through the code check and commit, with a
//  dictionary read for the first byte / length when the code is already a
//  dictionary entry; a code rejected at once skips the commit. A pull reads
//  one entry per prefix chain link; average phrase depth sets sustained rate.
//  Reset clears all control state at once; the dictionary has no clearing
//  pass, entries are only read after being written.
//  Receiver stall: the finished result sits in the output register; the
//  next word is accepted meanwhile, and its result waits for m_tready.
module lzw_stream_decoder_core #(
    parameter int MAX_WIDTH_BITS = lzwsd_pkg::LZWSD_MAX_WIDTH_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [1:0]  s_tuser,    // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [0] accepted, [8:1] out_byte, [10:9] status,
                                    // [12:11] error_kind, [15:13] zero
    output logic [0:0]  m_tuser,    // [0] out_valid
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import lzwsd_pkg::*;

    localparam int CW    = MAX_WIDTH_BITS;
    localparam int NW    = CW + 1;
    localparam int LW    = CW + 1;
    localparam int WW    = $clog2(CW + 1);
    localparam int DW    = CW + LW + 16;
    localparam int DEPTH = (1 << CW) - LITERAL_CODES;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_EXEC      = 4'd1;
    localparam logic [3:0] S_CODE      = 4'd2;
    localparam logic [3:0] S_CODE_RD   = 4'd3;
    localparam logic [3:0] S_COMMIT    = 4'd4;
    localparam logic [3:0] S_PULL      = 4'd5;
    localparam logic [3:0] S_PULL_WAIT = 4'd6;
    localparam logic [3:0] S_RESULT    = 4'd7;

    // config
    logic [3:0]  max_w_reg;
    logic [31:0] frame_reg;
    logic [31:0] limit_reg;

    // sequencer and item
    logic [3:0] state_reg, state_next;
    logic [1:0] op_reg, op_next;
    logic [7:0] byte_reg, byte_next;

    // decoder state
    logic [NW-1:0] nfc_reg, nfc_next;
    logic [WW-1:0] cur_w_reg, cur_w_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [WW-1:0] bh_reg, bh_next;
    logic [7:0]    hb_reg, hb_next;
    logic [3:0]    hbits_reg, hbits_next;
    logic [CW-1:0] prev_code_reg, prev_code_next;
    logic [7:0]    prev_first_reg, prev_first_next;
    logic [LW-1:0] prev_len_reg, prev_len_next;
    logic [CW-1:0] drain_code_reg, drain_code_next;
    logic [LW-1:0] drain_len_reg, drain_len_next;
    logic [LW-1:0] emit_reg, emit_next;
    logic [31:0]   bytes_out_reg, bytes_out_next;
    logic [31:0]   bytes_in_reg, bytes_in_next;
    logic [2:0]    mode_reg, mode_next;
    logic          first_pend_reg, first_pend_next;
    logic          end_seen_reg, end_seen_next;
    logic [1:0]    err_reg, err_next;

    // code being decoded
    logic [CW-1:0] code_reg, code_next;
    logic [7:0]    cfirst_reg, cfirst_next;
    logic [LW-1:0] clen_reg, clen_next;

    // result under construction
    logic       res_acc_reg, res_acc_next;
    logic       res_ov_reg, res_ov_next;
    logic [7:0] res_byte_reg, res_byte_next;
    logic [1:0] res_st_reg, res_st_next;

    // output register
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;
    logic        m_user_reg, m_user_next;

    // memory and walker
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          top_re;
    logic          walk_re;
    logic [CW-1:0] walk_addr;
    logic [DW-1:0] mem_rdata;
    logic          walk_start;
    walk_res_t     walk_res;

    logic [WW-1:0] eff_w;
    logic [NW-1:0] code_limit;

    always_comb begin
        if (int'(max_w_reg) < MIN_CODE_WIDTH) begin
            eff_w = WW'(MIN_CODE_WIDTH);
        end else if (int'(max_w_reg) > CW) begin
            eff_w = WW'(CW);
        end else begin
            eff_w = WW'(max_w_reg);
        end
    end

    assign code_limit = NW'(1) << eff_w;

    assign mem_waddr = CW'(nfc_reg - NW'(LITERAL_CODES));
    assign mem_wdata = {prev_code_reg, cfirst_reg, prev_first_reg,
                        LW'(prev_len_reg + LW'(1))};

    lzwsd_dict_ram #(
        .AW    (CW),
        .DW    (DW),
        .DEPTH (DEPTH)
    ) u_dict (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (top_re | walk_re),
        .raddr (walk_re ? walk_addr : (code_reg - CW'(LITERAL_CODES))),
        .rdata (mem_rdata)
    );

    lzwsd_chain_walk #(
        .CW (CW),
        .LW (LW)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (walk_start),
        .start_code (drain_code_reg),
        .start_off  (emit_reg),
        .next_free  (nfc_reg),
        .rd_en      (walk_re),
        .rd_addr    (walk_addr),
        .rd_data    (mem_rdata),
        .res        (walk_res)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_comb begin
        logic [2:0]    mode_v;
        logic [WW-1:0] cw_v;
        logic [WW-1:0] bh_v;
        logic [CW-1:0] acc_v;
        logic [7:0]    hb_v;
        logic [3:0]    hbits_v;
        logic [WW-1:0] need_v;
        logic [WW-1:0] n_v;
        logic [7:0]    mask_v;
        logic [LW-1:0] emit_v;
        logic [31:0]   bo_v;
        logic [1:0]    st_v;

        state_next      = state_reg;
        op_next         = op_reg;
        byte_next       = byte_reg;
        nfc_next        = nfc_reg;
        cur_w_next      = cur_w_reg;
        acc_next        = acc_reg;
        bh_next         = bh_reg;
        hb_next         = hb_reg;
        hbits_next      = hbits_reg;
        prev_code_next  = prev_code_reg;
        prev_first_next = prev_first_reg;
        prev_len_next   = prev_len_reg;
        drain_code_next = drain_code_reg;
        drain_len_next  = drain_len_reg;
        emit_next       = emit_reg;
        bytes_out_next  = bytes_out_reg;
        bytes_in_next   = bytes_in_reg;
        mode_next       = mode_reg;
        first_pend_next = first_pend_reg;
        end_seen_next   = end_seen_reg;
        err_next        = err_reg;
        code_next       = code_reg;
        cfirst_next     = cfirst_reg;
        clen_next       = clen_reg;
        res_acc_next    = res_acc_reg;
        res_ov_next     = res_ov_reg;
        res_byte_next   = res_byte_reg;
        res_st_next     = res_st_reg;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        mem_we          = 1'b0;
        top_re          = 1'b0;
        walk_start      = 1'b0;

        mode_v  = mode_reg;
        cw_v    = cur_w_reg;
        bh_v    = bh_reg;
        acc_v   = acc_reg;
        hb_v    = hb_reg;
        hbits_v = hbits_reg;
        need_v  = '0;
        n_v     = '0;
        mask_v  = '0;
        emit_v  = emit_reg + LW'(1);
        bo_v    = bytes_out_reg + 32'd1;
        st_v    = res_st_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next       = s_tuser;
                    byte_next     = s_tdata;
                    res_acc_next  = 1'b0;
                    res_ov_next   = 1'b0;
                    res_byte_next = 8'd0;
                    res_st_next   = ST_PROGRESS;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                // empty frame: go straight to waiting for end of input
                if (mode_reg == MODE_COLLECT && first_pend_reg && bytes_in_reg == 32'd0
                    && bh_reg == '0 && frame_reg == 32'd0) begin
                    mode_v = MODE_AWAIT;
                end
                mode_next  = mode_v;
                state_next = S_RESULT;
                if (mode_v == MODE_ERROR || mode_v == MODE_ENDED || op_reg == OP_NOP) begin
                    mode_next = mode_v;
                end else if (op_reg == OP_PUSH) begin
                    if (mode_v == MODE_AWAIT) begin
                        mode_next = MODE_ERROR;
                        err_next  = ERR_MALFORMED;
                    end else if (mode_v == MODE_COLLECT) begin
                        if (bytes_in_reg >= limit_reg) begin
                            mode_next = MODE_ERROR;
                            err_next  = ERR_LIMIT;
                        end else begin
                            // early change: widen before the first bit of a code
                            if (bh_v == '0 && !first_pend_reg && cw_v < eff_w
                                && nfc_reg == ((NW'(1) << cw_v) - NW'(1))) begin
                                cw_v = cw_v + WW'(1);
                            end
                            // leftover bits of the previous byte
                            if (hbits_v != 4'd0 && bh_v < cw_v) begin
                                need_v = cw_v - bh_v;
                                n_v    = (WW'(hbits_v) < need_v) ? WW'(hbits_v) : need_v;
                                mask_v = 8'((9'd1 << n_v) - 9'd1);
                                acc_v  = acc_v | (CW'(hb_v & mask_v) << bh_v);
                                bh_v   = bh_v + n_v;
                                hb_v   = hb_v >> n_v;
                                hbits_v = hbits_v - 4'(n_v);
                            end
                            if (bh_v < cw_v) begin
                                bytes_in_next = bytes_in_reg + 32'd1;
                                res_acc_next  = 1'b1;
                                need_v = cw_v - bh_v;
                                n_v    = (WW'(8) < need_v) ? WW'(8) : need_v;
                                mask_v = 8'((9'd1 << n_v) - 9'd1);
                                acc_v  = acc_v | (CW'(byte_reg & mask_v) << bh_v);
                                bh_v   = bh_v + n_v;
                                hb_v   = byte_reg >> n_v;
                                hbits_v = 4'd8 - 4'(n_v);
                            end
                            cur_w_next = cw_v;
                            hb_next    = hb_v;
                            hbits_next = hbits_v;
                            if (bh_v == cw_v) begin
                                code_next  = acc_v;
                                acc_next   = '0;
                                bh_next    = '0;
                                state_next = S_CODE;
                            end else begin
                                acc_next = acc_v;
                                bh_next  = bh_v;
                            end
                        end
                    end
                end else if (op_reg == OP_PULL) begin
                    if (mode_v == MODE_DRAIN) begin
                        state_next = S_PULL;
                    end else begin
                        res_st_next = ST_NEED_INPUT;
                    end
                end else begin
                    if (mode_v == MODE_DRAIN) begin
                        end_seen_next = 1'b1;
                    end else if (mode_v == MODE_AWAIT) begin
                        mode_next = MODE_ENDED;
                    end else begin
                        mode_next = MODE_ERROR;
                        err_next  = ERR_MALFORMED;
                    end
                end
            end
            S_CODE: begin
                state_next = S_COMMIT;
                if (first_pend_reg) begin
                    if (code_reg[CW-1:8] != '0) begin
                        mode_next  = MODE_ERROR;
                        err_next   = ERR_MALFORMED;
                        state_next = S_RESULT;
                    end else begin
                        cfirst_next     = code_reg[7:0];
                        clen_next       = LW'(1);
                        first_pend_next = 1'b0;
                    end
                end else if ({1'b0, code_reg} < nfc_reg) begin
                    if (code_reg[CW-1:8] == '0) begin
                        cfirst_next = code_reg[7:0];
                        clen_next   = LW'(1);
                    end else begin
                        top_re     = 1'b1;
                        state_next = S_CODE_RD;
                    end
                end else if ({1'b0, code_reg} == nfc_reg && nfc_reg < code_limit) begin
                    // KwKwK: previous phrase plus its own first byte
                    cfirst_next = prev_first_reg;
                    clen_next   = prev_len_reg + LW'(1);
                end else begin
                    mode_next  = MODE_ERROR;
                    err_next   = ERR_MALFORMED;
                    state_next = S_RESULT;
                end
            end
            S_CODE_RD: begin
                cfirst_next = mem_rdata[LW+7:LW];
                clen_next   = mem_rdata[LW-1:0];
                state_next  = S_COMMIT;
            end
            S_COMMIT: begin
                state_next = S_RESULT;
                if ((33'(bytes_out_reg) + 33'(clen_reg)) > 33'(frame_reg)) begin
                    mode_next = MODE_ERROR;
                    err_next  = ERR_MALFORMED;
                end else begin
                    if (prev_len_reg != '0 && nfc_reg < code_limit) begin
                        mem_we   = 1'b1;
                        nfc_next = nfc_reg + NW'(1);
                    end
                    prev_code_next  = code_reg;
                    prev_first_next = cfirst_reg;
                    prev_len_next   = clen_reg;
                    drain_code_next = code_reg;
                    drain_len_next  = clen_reg;
                    emit_next       = '0;
                    mode_next       = MODE_DRAIN;
                end
            end
            S_PULL: begin
                walk_start = 1'b1;
                state_next = S_PULL_WAIT;
            end
            S_PULL_WAIT: begin
                if (walk_res.done) begin
                    state_next = S_RESULT;
                    if (!walk_res.ok) begin
                        mode_next = MODE_ERROR;
                        err_next  = ERR_CHAIN;
                    end else begin
                        res_ov_next    = 1'b1;
                        res_byte_next  = walk_res.val;
                        bytes_out_next = bo_v;
                        if (emit_v == drain_len_reg) begin
                            drain_len_next = '0;
                            emit_next      = '0;
                            if (bo_v == frame_reg) begin
                                // frame done: leftover padding must be zero
                                if (hbits_reg != 4'd0 && hb_reg != 8'd0) begin
                                    mode_next = MODE_ERROR;
                                    err_next  = ERR_MALFORMED;
                                end else begin
                                    hb_next    = 8'd0;
                                    hbits_next = 4'd0;
                                    mode_next  = end_seen_reg ? MODE_ENDED : MODE_AWAIT;
                                end
                            end else begin
                                mode_next = MODE_COLLECT;
                            end
                        end else begin
                            emit_next = emit_v;
                        end
                    end
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    if (mode_reg == MODE_ERROR) begin
                        st_v = ST_ERROR;
                    end else if (mode_reg == MODE_ENDED) begin
                        st_v = ST_END;
                    end
                    m_valid_next = 1'b1;
                    m_user_next  = res_ov_reg;
                    m_data_next  = {3'd0,
                                    (mode_reg == MODE_ERROR) ? err_reg : ERR_NONE,
                                    st_v, res_byte_reg, res_acc_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_w_reg <= 4'd12;
            frame_reg <= 32'd0;
            limit_reg <= 32'hFFFF_FFFF;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_WIDTH:  max_w_reg <= cfg_data[3:0];
                CFG_FRAME_SIZE: frame_reg <= cfg_data;
                CFG_IN_LIMIT:   limit_reg <= cfg_data;
                default:        max_w_reg <= max_w_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            nfc_reg        <= NW'(LITERAL_CODES);
            cur_w_reg      <= WW'(MIN_CODE_WIDTH);
            acc_reg        <= '0;
            bh_reg         <= '0;
            hb_reg         <= '0;
            hbits_reg      <= '0;
            prev_code_reg  <= '0;
            prev_first_reg <= '0;
            prev_len_reg   <= '0;
            drain_code_reg <= '0;
            drain_len_reg  <= '0;
            emit_reg       <= '0;
            bytes_out_reg  <= '0;
            bytes_in_reg   <= '0;
            mode_reg       <= MODE_COLLECT;
            first_pend_reg <= 1'b1;
            end_seen_reg   <= 1'b0;
            err_reg        <= ERR_NONE;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            nfc_reg        <= nfc_next;
            cur_w_reg      <= cur_w_next;
            acc_reg        <= acc_next;
            bh_reg         <= bh_next;
            hb_reg         <= hb_next;
            hbits_reg      <= hbits_next;
            prev_code_reg  <= prev_code_next;
            prev_first_reg <= prev_first_next;
            prev_len_reg   <= prev_len_next;
            drain_code_reg <= drain_code_next;
            drain_len_reg  <= drain_len_next;
            emit_reg       <= emit_next;
            bytes_out_reg  <= bytes_out_next;
            bytes_in_reg   <= bytes_in_next;
            mode_reg       <= mode_next;
            first_pend_reg <= first_pend_next;
            end_seen_reg   <= end_seen_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        byte_reg     <= byte_next;
        code_reg     <= code_next;
        cfirst_reg   <= cfirst_next;
        clen_reg     <= clen_next;
        res_acc_reg  <= res_acc_next;
        res_ov_reg   <= res_ov_next;
        res_byte_reg <= res_byte_next;
        res_st_reg   <= res_st_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

endmodule
